[hdl/assert_macros.svh]
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, held off while reset is high
`define MRZ_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// concurrent check that also runs through reset
`define MRZ_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/mrz_pkg.sv]
// types, constants and helper functions for the z-axis row rotator
package mrz_pkg;

   // pipeline depth of the unrolled cordic
   localparam int CORDIC_STAGES = 16;

   // field widths
   localparam int ANGLE_W = 18;
   localparam int ELEM_W  = 32;

   // angle units: 1/256 degree
   localparam int DEG_STEPS          = 256;
   localparam int DEG_SHIFT          = $clog2(DEG_STEPS);
   localparam int HALF_DEGREES       = 180;
   localparam int HALF_TURN          = HALF_DEGREES * DEG_STEPS;
   localparam int FULL_TURN          = 2 * HALF_TURN;
   localparam int QUARTER_TURN       = HALF_TURN / 2;
   localparam int THREE_QUARTER_TURN = 3 * QUARTER_TURN;
   localparam int EIGHTH_TURN        = QUARTER_TURN / 2;
   localparam int EIGHTH_DIV         = EIGHTH_TURN / DEG_STEPS;

   // angle reduction widths
   localparam int WRAP_W      = ANGLE_W + 1;
   localparam int MAG_W       = 15;
   localparam int QUO_W       = 10;
   localparam int REM_W       = $clog2(EIGHTH_DIV);
   localparam int PRE_W       = REM_W + 1;
   localparam int RECIP_SHIFT = 16;
   localparam int RP_W        = MAG_W + 11;
   localparam int TAB_W       = 30;
   localparam int AK_W        = QUO_W + TAB_W;
   localparam int SUM_A_W     = AK_W + 1;
   localparam int THETA_MAG_W = 32;

   // trig and product widths (Q30)
   localparam int TRIG_BITS = 30;
   localparam int TRIG_W    = 33;
   localparam int PROD_W    = ELEM_W + TRIG_W;
   localparam int SUM_W     = PROD_W + 1;
   localparam int SH_W      = SUM_W - TRIG_BITS;

   // latencies in register stages
   localparam int ANGLE_LAT = 5;
   localparam int TRIG_LAT  = ANGLE_LAT + CORDIC_STAGES + 1;
   localparam int LANE_LAT  = 2;
   localparam int PIPE_LAT  = TRIG_LAT + LANE_LAT;

   // signed turn bounds for the wrap logic
   localparam logic signed [WRAP_W-1:0] FULL_S     = WRAP_W'(FULL_TURN);
   localparam logic signed [WRAP_W-1:0] HALF_S     = WRAP_W'(HALF_TURN);
   localparam logic signed [WRAP_W-1:0] QUARTER_S  = WRAP_W'(QUARTER_TURN);
   localparam logic signed [WRAP_W-1:0] THREEQ_S   = WRAP_W'(THREE_QUARTER_TURN);

   // divide by the eighth-turn factor: reciprocal plus one correction
   localparam logic [RP_W-1:0]  RECIP = RP_W'((1 << RECIP_SHIFT) / EIGHTH_DIV);
   localparam logic [MAG_W-1:0] DIV_M = MAG_W'(EIGHTH_DIV);
   localparam logic [PRE_W-1:0] DIV_P = PRE_W'(EIGHTH_DIV);

   // pi/4 in Q30 and inverse cordic gain in Q30
   localparam logic [TAB_W-1:0]         PI_QUARTER = 30'h3243F6A8;
   localparam logic signed [TRIG_W-1:0] GAIN_INV   = TRIG_W'(32'h26DD3B6A);

   // rounding constant for the Q30 product sum
   localparam logic [SUM_W-1:0] ROUND = SUM_W'(1) << (TRIG_BITS - 1);

   typedef struct packed {
      logic signed [ANGLE_W-1:0] angle;
      logic signed [ELEM_W-1:0]  row0_first;
      logic signed [ELEM_W-1:0]  row0_second;
      logic signed [ELEM_W-1:0]  row1_first;
      logic signed [ELEM_W-1:0]  row1_second;
   } req_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] new_row0_first;
      logic signed [ELEM_W-1:0] new_row0_second;
      logic signed [ELEM_W-1:0] new_row1_first;
      logic signed [ELEM_W-1:0] new_row1_second;
   } rsp_type;

   typedef struct packed {
      logic signed [ELEM_W-1:0] row0_first;
      logic signed [ELEM_W-1:0] row0_second;
      logic signed [ELEM_W-1:0] row1_first;
      logic signed [ELEM_W-1:0] row1_second;
   } rows_type;

   // reduced angle handed to the cordic
   typedef struct packed {
      logic signed [TRIG_W-1:0] theta;
      logic                     flip;
   } angle_type;

   // sine and cosine handed to the row lanes
   typedef struct packed {
      logic signed [TRIG_W-1:0] cosine;
      logic signed [TRIG_W-1:0] sine;
      logic signed [TRIG_W-1:0] neg_sine;
   } trig_type;

   // atan(2^-i) in Q30, truncated
   function automatic logic [31:0] atan_q30(input int idx);
      logic [31:0] val;
      unique case (idx)
         0:       val = 32'h3243F6A8;
         1:       val = 32'h1DAC6705;
         2:       val = 32'h0FADBAFC;
         3:       val = 32'h07F56EA6;
         4:       val = 32'h03FEAB76;
         5:       val = 32'h01FFD55B;
         6:       val = 32'h00FFFAAA;
         7:       val = 32'h007FFF55;
         8:       val = 32'h003FFFEA;
         9:       val = 32'h001FFFFD;
         10:      val = 32'h000FFFFF;
         11:      val = 32'h0007FFFF;
         12:      val = 32'h0003FFFF;
         13:      val = 32'h0001FFFF;
         14:      val = 32'h0000FFFF;
         15:      val = 32'h00007FFF;
         16:      val = 32'h00003FFF;
         17:      val = 32'h00001FFF;
         18:      val = 32'h00000FFF;
         19:      val = 32'h000007FF;
         20:      val = 32'h000003FF;
         21:      val = 32'h000001FF;
         22:      val = 32'h000000FF;
         23:      val = 32'h0000007F;
         24:      val = 32'h0000003F;
         25:      val = 32'h0000001F;
         26:      val = 32'h0000000F;
         27:      val = 32'h00000008;
         28:      val = 32'h00000004;
         29:      val = 32'h00000002;
         30:      val = 32'h00000001;
         default: val = 32'h00000000;
      endcase
      return val;
   endfunction

   // clamp a scaled sum to the element range
   function automatic logic signed [ELEM_W-1:0] sat_elem(input logic signed [SH_W-1:0] v);
      logic signed [ELEM_W-1:0] res;
      if ((&v[SH_W-1:ELEM_W-1]) || !(|v[SH_W-1:ELEM_W-1])) begin
         res = v[ELEM_W-1:0];
      end else if (v[SH_W-1]) begin
         res = {1'b1, {(ELEM_W-1){1'b0}}};
      end else begin
         res = {1'b0, {(ELEM_W-1){1'b1}}};
      end
      return res;
   endfunction

endpackage

[hdl/mrz_angle.sv]
// angle wrap, quadrant fold and conversion to Q30 radians
module mrz_angle (
   input  logic                               clock,
   input  logic                               en,
   input  logic signed [mrz_pkg::ANGLE_W-1:0] angle,
   output mrz_pkg::angle_type                 result
);
   import mrz_pkg::*;

   logic signed [WRAP_W-1:0] wrap_a;
   logic signed [WRAP_W-1:0] wrap_t;
   logic signed [WRAP_W-1:0] red_r;
   logic                     red_flip;
   logic                     red_neg;
   logic [MAG_W-1:0]         red_mag;

   logic [MAG_W-1:0]         s1_mag_ff;
   logic                     s1_neg_ff;
   logic                     s1_flip_ff;

   logic [RP_W-1:0]          s2_prod_ff;
   logic [MAG_W-1:0]         s2_mag_ff;
   logic                     s2_neg_ff;
   logic                     s2_flip_ff;

   logic [QUO_W-1:0]         q_est;
   logic [MAG_W-1:0]         q_back;
   logic [MAG_W-1:0]         rem_full;
   logic [PRE_W-1:0]         rem_est;
   logic [QUO_W-1:0]         quo_in;
   logic [REM_W-1:0]         rem_in;

   logic [QUO_W-1:0]         s3_quo_ff;
   logic [REM_W-1:0]         s3_rem_ff;
   logic                     s3_neg_ff;
   logic                     s3_flip_ff;

   logic [TAB_W-1:0]         tab [EIGHTH_DIV];

   logic [AK_W-1:0]          s4_ak_ff;
   logic [TAB_W-1:0]         s4_tab_ff;
   logic                     s4_neg_ff;
   logic                     s4_flip_ff;

   logic [SUM_A_W-1:0]       sum_a;
   logic [TRIG_W-1:0]        theta_ext;
   angle_type                result_in;
   angle_type                result_ff;

   // wrap into one turn, then fold to within a quarter turn
   always_comb begin
      wrap_a = WRAP_W'(angle);
      if (wrap_a >= FULL_S) begin
         wrap_t = wrap_a - FULL_S;
      end else if (wrap_a < 0) begin
         wrap_t = wrap_a + FULL_S;
         if (wrap_t < 0) begin
            wrap_t = wrap_t + FULL_S;
         end
      end else begin
         wrap_t = wrap_a;
      end
      red_flip = 1'b0;
      if (wrap_t > THREEQ_S) begin
         red_r = wrap_t - FULL_S;
      end else if (wrap_t > QUARTER_S) begin
         red_r    = wrap_t - HALF_S;
         red_flip = 1'b1;
      end else begin
         red_r = wrap_t;
      end
      red_neg = red_r[WRAP_W-1];
      red_mag = red_neg ? MAG_W'(-red_r) : MAG_W'(red_r);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_mag_ff  <= red_mag;
         s1_neg_ff  <= red_neg;
         s1_flip_ff <= red_flip;
      end
   end

   // reciprocal estimate of magnitude over the eighth-turn factor
   always_ff @(posedge clock) begin
      if (en) begin
         s2_prod_ff <= RP_W'(s1_mag_ff) * RECIP;
         s2_mag_ff  <= s1_mag_ff;
         s2_neg_ff  <= s1_neg_ff;
         s2_flip_ff <= s1_flip_ff;
      end
   end

   // one correction step gives exact quotient and remainder
   always_comb begin
      q_est    = s2_prod_ff[RECIP_SHIFT +: QUO_W];
      q_back   = MAG_W'(MAG_W'(q_est) * DIV_M);
      rem_full = s2_mag_ff - q_back;
      rem_est  = rem_full[PRE_W-1:0];
      if (rem_est >= DIV_P) begin
         quo_in = q_est + QUO_W'(1);
         rem_in = REM_W'(rem_est - DIV_P);
      end else begin
         quo_in = q_est;
         rem_in = rem_est[REM_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s3_quo_ff  <= quo_in;
         s3_rem_ff  <= rem_in;
         s3_neg_ff  <= s2_neg_ff;
         s3_flip_ff <= s2_flip_ff;
      end
   end

   // remainder table: rounded pi/4 share of each remainder, pre-divided
   for (genvar gi = 0; gi < EIGHTH_DIV; gi++) begin : g_tab
      assign tab[gi] = TAB_W'((64'(gi) * 64'(PI_QUARTER) + 64'(EIGHTH_TURN / 2))
                              / 64'(EIGHTH_DIV));
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s4_ak_ff   <= AK_W'(s3_quo_ff) * AK_W'(PI_QUARTER);
         s4_tab_ff  <= tab[s3_rem_ff];
         s4_neg_ff  <= s3_neg_ff;
         s4_flip_ff <= s3_flip_ff;
      end
   end

   // combine and drop the degree-step scaling, restore sign
   always_comb begin
      sum_a            = SUM_A_W'(s4_ak_ff) + SUM_A_W'(s4_tab_ff);
      theta_ext        = {1'b0, sum_a[DEG_SHIFT +: THETA_MAG_W]};
      result_in.theta  = s4_neg_ff ? -theta_ext : theta_ext;
      result_in.flip   = s4_flip_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

[hdl/mrz_cordic.sv]
// unrolled cordic rotation, one register stage per iteration
module mrz_cordic (
   input  logic               clock,
   input  logic               en,
   input  mrz_pkg::angle_type angle_in,
   output mrz_pkg::trig_type  trig
);
   import mrz_pkg::*;

   logic signed [TRIG_W-1:0] x_ff    [CORDIC_STAGES];
   logic signed [TRIG_W-1:0] y_ff    [CORDIC_STAGES];
   logic signed [TRIG_W-1:0] z_ff    [CORDIC_STAGES];
   logic                     flip_ff [CORDIC_STAGES];

   trig_type                 trig_in;
   trig_type                 trig_ff;

   for (genvar gi = 0; gi < CORDIC_STAGES; gi++) begin : g_stage
      logic signed [TRIG_W-1:0] x_prev;
      logic signed [TRIG_W-1:0] y_prev;
      logic signed [TRIG_W-1:0] z_prev;
      logic                     flip_prev;
      logic signed [TRIG_W-1:0] x_in;
      logic signed [TRIG_W-1:0] y_in;
      logic signed [TRIG_W-1:0] z_in;

      // stage input: start vector or previous stage
      if (gi == 0) begin : g_first
         assign x_prev    = GAIN_INV;
         assign y_prev    = '0;
         assign z_prev    = angle_in.theta;
         assign flip_prev = angle_in.flip;
      end else begin : g_next
         assign x_prev    = x_ff[gi-1];
         assign y_prev    = y_ff[gi-1];
         assign z_prev    = z_ff[gi-1];
         assign flip_prev = flip_ff[gi-1];
      end

      // micro-rotation towards zero residual angle
      always_comb begin
         if (!z_prev[TRIG_W-1]) begin
            x_in = x_prev - (y_prev >>> gi);
            y_in = y_prev + (x_prev >>> gi);
            z_in = z_prev - TRIG_W'(atan_q30(gi));
         end else begin
            x_in = x_prev + (y_prev >>> gi);
            y_in = y_prev - (x_prev >>> gi);
            z_in = z_prev + TRIG_W'(atan_q30(gi));
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            x_ff[gi]    <= x_in;
            y_ff[gi]    <= y_in;
            z_ff[gi]    <= z_in;
            flip_ff[gi] <= flip_prev;
         end
      end
   end

   // undo the half-turn fold
   always_comb begin
      if (flip_ff[CORDIC_STAGES-1]) begin
         trig_in.cosine   = -x_ff[CORDIC_STAGES-1];
         trig_in.sine     = -y_ff[CORDIC_STAGES-1];
         trig_in.neg_sine = y_ff[CORDIC_STAGES-1];
      end else begin
         trig_in.cosine   = x_ff[CORDIC_STAGES-1];
         trig_in.sine     = y_ff[CORDIC_STAGES-1];
         trig_in.neg_sine = -y_ff[CORDIC_STAGES-1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         trig_ff <= trig_in;
      end
   end

   assign trig = trig_ff;

endmodule

[hdl/mrz_lane.sv]
// one row lane: two products per output, round and saturate
module mrz_lane (
   input  logic                              clock,
   input  logic                              en,
   input  logic signed [mrz_pkg::ELEM_W-1:0] row_first,
   input  logic signed [mrz_pkg::ELEM_W-1:0] row_second,
   input  mrz_pkg::trig_type                 trig,
   output logic signed [mrz_pkg::ELEM_W-1:0] new_first,
   output logic signed [mrz_pkg::ELEM_W-1:0] new_second
);
   import mrz_pkg::*;

   logic signed [PROD_W-1:0] pc_ff;
   logic signed [PROD_W-1:0] qs_ff;
   logic signed [PROD_W-1:0] pn_ff;
   logic signed [PROD_W-1:0] qc_ff;

   logic [SUM_W-1:0]         sum_first;
   logic [SUM_W-1:0]         sum_second;
   logic signed [ELEM_W-1:0] first_ff;
   logic signed [ELEM_W-1:0] second_ff;

   // four products, registered
   always_ff @(posedge clock) begin
      if (en) begin
         pc_ff <= PROD_W'(row_first) * PROD_W'(trig.cosine);
         qs_ff <= PROD_W'(row_second) * PROD_W'(trig.sine);
         pn_ff <= PROD_W'(row_first) * PROD_W'(trig.neg_sine);
         qc_ff <= PROD_W'(row_second) * PROD_W'(trig.cosine);
      end
   end

   // add with rounding, drop fraction bits of the trig format
   always_comb begin
      sum_first  = SUM_W'(pc_ff) + SUM_W'(qs_ff) + ROUND;
      sum_second = SUM_W'(pn_ff) + SUM_W'(qc_ff) + ROUND;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         first_ff  <= sat_elem(sum_first[SUM_W-1:TRIG_BITS]);
         second_ff <= sat_elem(sum_second[SUM_W-1:TRIG_BITS]);
      end
   end

   assign new_first  = first_ff;
   assign new_second = second_ff;

endmodule

[hdl/matrix_rows_z_rotate.sv]
// Rotates the upper-left 2x2 of a transform matrix about z by the negated angle.
// One item is accepted per clock whenever req_ready is high, and results leave
// in order. An item crosses five register stages of angle wrap and conversion
// to radians, the first loading at the accepting edge, then one per cordic
// iteration, one for the quadrant fix-up, two in the row lanes and one in the
// output register. All stages ahead of the output register advance together;
// a skid register behind the output holds one item while the consumer stalls,
// and req_ready drops only while it is occupied. Elements pass through in their
// own fixed-point format, rounded and saturated to 32 bits.
module matrix_rows_z_rotate (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  mrz_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output mrz_pkg::rsp_type rsp_data
);
   import mrz_pkg::*;

   logic      en;
   logic      vld_ff  [PIPE_LAT];
   rows_type  rows_ff [TRIG_LAT];
   rows_type  rows_in;

   angle_type angle_res;
   trig_type  trig;
   rsp_type   pipe_rsp;
   logic      pipe_valid;

   logic      out_valid_ff;
   rsp_type   out_data_ff;
   logic      skid_valid_ff;
   rsp_type   skid_data_ff;

   // pipeline moves whenever the skid register is free
   assign en        = !skid_valid_ff;
   assign req_ready = en;

   // item valid tracking along the pipeline
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < PIPE_LAT; k++) begin
            vld_ff[k] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int k = 1; k < PIPE_LAT; k++) begin
            vld_ff[k] <= vld_ff[k-1];
         end
      end
   end

   // row elements wait for their sine and cosine
   always_comb begin
      rows_in.row0_first  = req_data.row0_first;
      rows_in.row0_second = req_data.row0_second;
      rows_in.row1_first  = req_data.row1_first;
      rows_in.row1_second = req_data.row1_second;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rows_ff[0] <= rows_in;
         for (int k = 1; k < TRIG_LAT; k++) begin
            rows_ff[k] <= rows_ff[k-1];
         end
      end
   end

   mrz_angle u_angle (
      .clock  (clock),
      .en     (en),
      .angle  (req_data.angle),
      .result (angle_res)
   );

   mrz_cordic u_cordic (
      .clock    (clock),
      .en       (en),
      .angle_in (angle_res),
      .trig     (trig)
   );

   mrz_lane u_lane0 (
      .clock      (clock),
      .en         (en),
      .row_first  (rows_ff[TRIG_LAT-1].row0_first),
      .row_second (rows_ff[TRIG_LAT-1].row0_second),
      .trig       (trig),
      .new_first  (pipe_rsp.new_row0_first),
      .new_second (pipe_rsp.new_row0_second)
   );

   mrz_lane u_lane1 (
      .clock      (clock),
      .en         (en),
      .row_first  (rows_ff[TRIG_LAT-1].row1_first),
      .row_second (rows_ff[TRIG_LAT-1].row1_second),
      .trig       (trig),
      .new_first  (pipe_rsp.new_row1_first),
      .new_second (pipe_rsp.new_row1_second)
   );

   assign pipe_valid = vld_ff[PIPE_LAT-1];

   // output register and skid control
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (rsp_ready) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (pipe_valid) begin
         if (!out_valid_ff || rsp_ready) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (rsp_ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   // merged lane results into output or skid
   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (rsp_ready) begin
            out_data_ff <= skid_data_ff;
         end
      end else if (pipe_valid) begin
         if (!out_valid_ff || rsp_ready) begin
            out_data_ff <= pipe_rsp;
         end else begin
            skid_data_ff <= pipe_rsp;
         end
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

endmodule

[hdl/mrz_checker.sv]
// port-level checks for the row rotator, bound to the top level
`include "assert_macros.svh"

module mrz_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_ready,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input mrz_pkg::rsp_type rsp_data
);
   import mrz_pkg::*;

   // reset empties the output and opens the input
   `MRZ_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> (!rsp_valid && req_ready), "output not empty after reset")

   // a stalled item keeps its value
   `MRZ_ASSERT(a_rsp_hold, clock, reset, (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_data)), "stalled item changed")

   // input closes only behind a stalled output
   `MRZ_ASSERT(a_ready_cause, clock, reset, !req_ready |-> $past(rsp_valid && !rsp_ready), "input closed without output stall")

   // empty output means the skid is empty too
   `MRZ_ASSERT(a_empty_ready, clock, reset, !rsp_valid |-> req_ready, "input closed with empty output")

endmodule

bind matrix_rows_z_rotate mrz_checker u_mrz_checker (.*);
